[sv/dsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dsm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_REPORT  = 2'd3
    } op_t;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_STAR = 8'h2A;

    // decoded command handed from front to back
    typedef struct packed {
        op_t        op;
        logic       is_star;
        logic       is_any;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic matched;
        logic too_long;
    } res_t;

endpackage

`default_nettype wire

[sv/dot_star_pattern_matcher.sv]
// Whole-string matcher for patterns of literal bytes, '.' and '*'.
// Input channel: a transaction is taken when push is high and full is low.
//   req_type 0 clears the job, 1 appends a pattern byte, 2 feeds a subject
//   byte, 3 requests a report; char_in carries the byte for types 1 and 2.
// Result channel: a report sits on matched/too_long while empty is low and
//   leaves on a clock edge with pop high and empty low.
// Path: a report transaction is registered in the command queue, then executed
//   into the result queue, from which it reaches the result ports.
// Throughput: one transaction per cycle while full is low. The back end executes
//   each command combinationally; the subject step is a bit-parallel NFA update
//   followed by a ripple through up to MAX_ELEMENTS starred elements.
// Stalls: when the result queue fills, reports wait in the two-entry command
//   queue; full rises once that queue is full too. Non-report transactions
//   keep flowing as long as no report is stuck at the head.
// Reset: clears both queues, empties the pattern, and leaves only position
//   zero active, the same as a clear transaction. No clearing pass is needed.
// A pattern needing more than MAX_ELEMENTS elements sets too_long; later
//   pattern bytes of that job are dropped and matched reads 0.
`timescale 1ns / 1ps
`default_nettype none

module dot_star_pattern_matcher #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] char_in,
    output logic            empty,
    input  wire logic       pop,
    output logic            matched,
    output logic            too_long
);

    logic          cmd_valid;
    logic          cmd_ready;
    dsm_pkg::cmd_t cmd;

    // front: decode and queue incoming transactions
    dsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .char_in   (char_in),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: pattern store, NFA state and report queue
    dsm_back #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .matched   (matched),
        .too_long  (too_long)
    );

endmodule

`default_nettype wire

[sv/dsm_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

// two-entry queue, push and pop may complete in the same cycle
module dsm_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [2];
    logic [1:0]       cnt_reg, cnt_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[sv/dsm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// decodes request transactions and queues them for the back end
module dsm_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  char_in,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output dsm_pkg::cmd_t    cmd
);

    dsm_pkg::cmd_t                 dec;
    logic [$bits(dsm_pkg::cmd_t)-1:0] q_rdata;
    logic                          q_empty;

    always_comb
    begin
        dec.op      = dsm_pkg::op_t'(req_type);
        dec.is_star = (char_in == dsm_pkg::CHAR_STAR);
        dec.is_any  = (char_in == dsm_pkg::CHAR_DOT);
        dec.ch      = char_in;
    end

    dsm_fifo #(
        .WIDTH($bits(dsm_pkg::cmd_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (dec),
        .pop   (cmd_ready),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = dsm_pkg::cmd_t'(q_rdata);

endmodule

`default_nettype wire

[sv/dsm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

// element store, NFA position vector and result queue
module dsm_back #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire dsm_pkg::cmd_t cmd,
    output logic               empty,
    input  wire logic          pop,
    output logic               matched,
    output logic               too_long
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    logic [7:0] elem_byte_reg [MAX_ELEMENTS];
    logic       elem_any_reg  [MAX_ELEMENTS];
    logic       elem_star_reg [MAX_ELEMENTS];

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  star_ok_reg, star_ok_next;
    logic                  ovf_reg, ovf_next;
    // kept closed over starred elements at all times
    logic [MAX_ELEMENTS:0] active_reg, active_next;

    logic                  elem_wr_en;
    logic                  star_set_en;
    logic [CNT_W-1:0]      last_cnt;
    logic [IDX_W-1:0]      wr_idx, last_idx;
    logic [MAX_ELEMENTS:0] step_vec;

    logic                  res_full;
    logic                  exec;
    dsm_pkg::res_t         res_in;
    logic [$bits(dsm_pkg::res_t)-1:0] res_out;
    dsm_pkg::res_t         res_head;

    assign cmd_ready = !(cmd.op == dsm_pkg::OP_REPORT && res_full);
    assign exec      = cmd_valid && cmd_ready;
    assign last_cnt  = count_reg - CNT_W'(1);
    assign wr_idx    = count_reg[IDX_W-1:0];
    assign last_idx  = last_cnt[IDX_W-1:0];

    // one subject byte: advance, then ripple through starred elements
    always_comb
    begin
        step_vec = '0;
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            if (active_reg[i] && (CNT_W'(i) < count_reg)
                && (elem_any_reg[i] || elem_byte_reg[i] == cmd.ch))
            begin
                if (elem_star_reg[i])
                begin
                    step_vec[i] = 1'b1;
                end
                else
                begin
                    step_vec[i+1] = 1'b1;
                end
            end
        end
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            if (step_vec[i] && elem_star_reg[i] && (CNT_W'(i) < count_reg))
            begin
                step_vec[i+1] = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        star_ok_next = star_ok_reg;
        ovf_next     = ovf_reg;
        active_next  = active_reg;
        elem_wr_en   = 1'b0;
        star_set_en  = 1'b0;
        if (exec)
        begin
            unique case (cmd.op)
                dsm_pkg::OP_CLEAR:
                begin
                    count_next   = '0;
                    star_ok_next = 1'b0;
                    ovf_next     = 1'b0;
                    active_next  = (MAX_ELEMENTS + 1)'(1);
                end
                dsm_pkg::OP_APPEND:
                begin
                    if (!ovf_reg)
                    begin
                        if (cmd.is_star && star_ok_reg && count_reg != '0)
                        begin
                            star_set_en  = 1'b1;
                            star_ok_next = 1'b0;
                            if (active_reg[last_cnt])
                            begin
                                active_next[count_reg] = 1'b1;
                            end
                        end
                        else if (count_reg >= MAX_CNT)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            elem_wr_en   = 1'b1;
                            count_next   = count_reg + CNT_W'(1);
                            star_ok_next = 1'b1;
                        end
                    end
                end
                dsm_pkg::OP_SUBJECT:
                begin
                    active_next = step_vec;
                end
                dsm_pkg::OP_REPORT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            star_ok_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            active_reg  <= (MAX_ELEMENTS + 1)'(1);
        end
        else
        begin
            count_reg   <= count_next;
            star_ok_reg <= star_ok_next;
            ovf_reg     <= ovf_next;
            active_reg  <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_wr_en)
        begin
            elem_byte_reg[wr_idx] <= cmd.ch;
            elem_any_reg[wr_idx]  <= cmd.is_any;
            elem_star_reg[wr_idx] <= 1'b0;
        end
        if (star_set_en)
        begin
            elem_star_reg[last_idx] <= 1'b1;
        end
    end

    always_comb
    begin
        res_in.matched  = !ovf_reg && active_reg[count_reg];
        res_in.too_long = ovf_reg;
    end

    dsm_fifo #(
        .WIDTH($bits(dsm_pkg::res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (exec && cmd.op == dsm_pkg::OP_REPORT),
        .full  (res_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (res_out)
    );

    assign res_head = dsm_pkg::res_t'(res_out);
    assign matched  = res_head.matched;
    assign too_long = res_head.too_long;

endmodule

`default_nettype wire

[verif/dot_star_pattern_matcher_tb.sv]
`timescale 1ns / 1ps

module dot_star_pattern_matcher_tb;

    // Store size of the dut as built (default parameter).
    localparam int MAX_ELEMS = 16;
    // Rough count of input transactions in the random part.
    localparam int ITEM_TARGET = 1750;
    // Long receiver hold-off used to back the block up until full rises.
    localparam int HOLD_CYCLES = 300;
    // Reports pass through the command and result queues; margin on top.
    localparam int DRAIN_CYCLES = 20;

    // Tracks the job the same way the block should: element store, star rules,
    // active-position vector, overflow flag. Each report taken on the input side
    // queues the outcome the block must deliver.
    class matcher_model;
        logic [7:0]         elem_byte [MAX_ELEMS];
        bit                 elem_any  [MAX_ELEMS];
        bit                 elem_star [MAX_ELEMS];
        int                 elem_count;
        bit                 star_ok;
        bit [MAX_ELEMS:0]   active;
        bit                 overflow;
        dsm_pkg::res_t      expected_reports [$];
        int unsigned        mismatches;

        function new();
            mismatches = 0;
            clear_job();
        endfunction

        function void clear_job();
            for (int i = 0; i < MAX_ELEMS; i++) begin
                elem_byte[i] = '0;
                elem_any[i]  = 1'b0;
                elem_star[i] = 1'b0;
            end
            elem_count = 0;
            star_ok    = 1'b0;
            active     = (MAX_ELEMS + 1)'(1);
            overflow   = 1'b0;
        endfunction

        // A starred element lets its position pass straight to the next one.
        function bit [MAX_ELEMS:0] close_stars(bit [MAX_ELEMS:0] a);
            for (int i = 0; i < elem_count; i++)
                if (a[i] && elem_star[i])
                    a[i + 1] = 1'b1;
            return a;
        endfunction

        function void add_pattern_byte(logic [7:0] ch);
            if (overflow)
                return;
            if (ch == dsm_pkg::CHAR_STAR && star_ok && elem_count > 0) begin
                elem_star[elem_count - 1] = 1'b1;
                star_ok = 1'b0;
                return;
            end
            if (elem_count >= MAX_ELEMS) begin
                overflow = 1'b1;
                return;
            end
            elem_byte[elem_count] = ch;
            elem_any[elem_count]  = (ch == dsm_pkg::CHAR_DOT);
            elem_star[elem_count] = 1'b0;
            elem_count++;
            star_ok = 1'b1;
        endfunction

        function void advance_positions(logic [7:0] ch);
            bit [MAX_ELEMS:0] a;
            bit [MAX_ELEMS:0] nxt;
            a   = close_stars(active);
            nxt = '0;
            for (int i = 0; i < elem_count; i++) begin
                if (a[i] && (elem_any[i] || elem_byte[i] == ch)) begin
                    if (elem_star[i])
                        nxt[i] = 1'b1;
                    else
                        nxt[i + 1] = 1'b1;
                end
            end
            active = close_stars(nxt);
        endfunction

        // Called for every accepted input transaction.
        function void note_transaction(dsm_pkg::op_t op, logic [7:0] ch);
            bit [MAX_ELEMS:0] a;
            dsm_pkg::res_t    want;
            case (op)
                dsm_pkg::OP_CLEAR:   clear_job();
                dsm_pkg::OP_APPEND:  add_pattern_byte(ch);
                dsm_pkg::OP_SUBJECT: advance_positions(ch);
                default:
                begin
                    a = close_stars(active);
                    want.matched  = !overflow && a[elem_count];
                    want.too_long = overflow;
                    expected_reports.push_back(want);
                end
            endcase
        endfunction

        // Called for every accepted result transaction.
        function void check_report(logic m, logic t);
            dsm_pkg::res_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report: expected none, actual matched=%b too_long=%b",
                         $time, m, t);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            if (m !== want.matched) begin
                $display("%0t: matched: expected %b, actual %b", $time, want.matched, m);
                mismatches++;
            end
            if (t !== want.too_long) begin
                $display("%0t: too_long: expected %b, actual %b", $time, want.too_long, t);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       push     = 1'b0;
    logic [1:0] req_type = dsm_pkg::OP_CLEAR;
    logic [7:0] char_in  = '0;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    logic       matched;
    logic       too_long;

    matcher_model model;

    // Idling controls shared between the two sides.
    bit tx_gaps      = 1'b0;
    bit rx_gaps      = 1'b0;
    bit hold_results = 1'b0;
    int items_sent   = 0;

    dot_star_pattern_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .req_type (req_type),
        .char_in  (char_in),
        .empty    (empty),
        .pop      (pop),
        .matched  (matched),
        .too_long (too_long)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Random byte for char_in.
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one input transaction and wait until the block takes it. push is
    // left high afterward so back-to-back transactions need no dead cycle;
    // anything that lets time pass outside this task must drop push first.
    task automatic send_item(input dsm_pkg::op_t op, input logic [7:0] ch);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        push     <= 1'b1;
        req_type <= op;
        char_in  <= ch;
        do
            @(posedge clk);
        while (full);
        model.note_transaction(op, ch);
        items_sent++;
    endtask

    // Subject-side byte mix: mostly the letters the patterns use, some stars,
    // some fully random bytes so every bit of char_in toggles.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0, 2:    return "a";
            1:       return "b";
            3:       return dsm_pkg::CHAR_STAR;
            default: return rand_byte();
        endcase
    endfunction

    // One random job: clear, a pattern built element by element, a subject
    // that mostly matches it (sometimes damaged, sometimes unrelated), then
    // a report, with the odd repeated report or late pattern growth.
    task automatic run_job(input bit force_long);
        int         n_elem;
        int         reps;
        int         mode;
        int         r;
        logic [7:0] b;
        bit         s;
        logic [7:0] elem_b [$];
        bit         elem_s [$];
        logic [7:0] subj [$];

        // Line noise between jobs: random type and byte.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                send_item(dsm_pkg::op_t'($urandom_range(0, 3)), rand_byte());

        send_item(dsm_pkg::OP_CLEAR, rand_byte());

        // Mostly short patterns; some run past the store to hit too_long.
        if (force_long || $urandom_range(0, 9) == 0)
            n_elem = $urandom_range(MAX_ELEMS - 1, MAX_ELEMS + 3);
        else
            n_elem = $urandom_range(0, 6);

        for (int k = 0; k < n_elem; k++) begin
            case ($urandom_range(0, 7))
                0, 1, 2: b = "a";
                3:       b = "b";
                4, 5:    b = dsm_pkg::CHAR_DOT;
                6:       b = dsm_pkg::CHAR_STAR;
                default: b = rand_byte();
            endcase
            // A star only stands as a literal at the start or after a starred one.
            if (b == dsm_pkg::CHAR_STAR && k > 0 && !elem_s[k - 1])
                b = "b";
            s = ($urandom_range(0, 2) == 0);
            elem_b.push_back(b);
            elem_s.push_back(s);
            send_item(dsm_pkg::OP_APPEND, b);
            if (s)
                send_item(dsm_pkg::OP_APPEND, dsm_pkg::CHAR_STAR);
        end

        mode = $urandom_range(0, 3);
        if (mode < 3) begin
            for (int k = 0; k < elem_b.size(); k++) begin
                reps = elem_s[k] ? $urandom_range(0, 3) : 1;
                repeat (reps)
                    subj.push_back(elem_b[k] == dsm_pkg::CHAR_DOT ? rand_byte()
                                                                  : elem_b[k]);
            end
            if (mode == 2 && subj.size() > 0)
                subj[$urandom_range(0, subj.size() - 1)] = pick_byte();
        end else begin
            repeat ($urandom_range(0, 8))
                subj.push_back(pick_byte());
        end

        foreach (subj[k])
            send_item(dsm_pkg::OP_SUBJECT, subj[k]);
        send_item(dsm_pkg::OP_REPORT, rand_byte());

        r = $urandom_range(0, 9);
        if (r < 2) begin
            send_item(dsm_pkg::OP_REPORT, rand_byte());
        end else if (r == 2) begin
            // report does not end the job: the subject keeps going
            repeat ($urandom_range(1, 3))
                send_item(dsm_pkg::OP_SUBJECT, pick_byte());
            send_item(dsm_pkg::OP_REPORT, rand_byte());
        end else if (r == 3) begin
            // pattern grows after subject bytes were taken
            send_item(dsm_pkg::OP_APPEND,
                      $urandom_range(0, 1) ? dsm_pkg::CHAR_STAR : pick_byte());
            send_item(dsm_pkg::OP_SUBJECT, pick_byte());
            send_item(dsm_pkg::OP_REPORT, rand_byte());
        end
    endtask

    // Result side: pops with random bursts of idle, plus one long hold-off on
    // request so the block's queues fill and full asserts. Outputs are read
    // right after the edge, i.e. the values the edge itself saw.
    initial begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_results) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty)
                model.check_report(matched, too_long);
        end
    end

    // Stimulus: reset, directed corner cases, then random jobs.
    initial begin
        bit hold_done;
        bit drain_done;
        bit late;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        model = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // Directed part. Empty pattern against empty subject matches.
        send_item(dsm_pkg::OP_REPORT, 8'hFF);
        // Leading star becomes a literal '*', the next star repeats it.
        send_item(dsm_pkg::OP_APPEND, dsm_pkg::CHAR_STAR);
        send_item(dsm_pkg::OP_APPEND, dsm_pkg::CHAR_STAR);
        send_item(dsm_pkg::OP_APPEND, dsm_pkg::CHAR_DOT);
        send_item(dsm_pkg::OP_SUBJECT, dsm_pkg::CHAR_STAR);
        // '.' takes byte zero like any other byte.
        send_item(dsm_pkg::OP_SUBJECT, 8'h00);
        send_item(dsm_pkg::OP_REPORT, 8'h00);
        // Repeated report gives the same answer.
        send_item(dsm_pkg::OP_REPORT, 8'h5A);
        // Subject continues after a report: now one byte too many.
        send_item(dsm_pkg::OP_SUBJECT, 8'hFF);
        send_item(dsm_pkg::OP_REPORT, 8'hA5);
        send_item(dsm_pkg::OP_CLEAR, 8'hFF);
        send_item(dsm_pkg::OP_APPEND, "a");
        send_item(dsm_pkg::OP_SUBJECT, "a");
        // Pattern grows after subject bytes: 'b*' then doubled star as literal.
        send_item(dsm_pkg::OP_APPEND, "b");
        send_item(dsm_pkg::OP_APPEND, dsm_pkg::CHAR_STAR);
        send_item(dsm_pkg::OP_APPEND, dsm_pkg::CHAR_STAR);
        send_item(dsm_pkg::OP_REPORT, 8'h00);
        send_item(dsm_pkg::OP_SUBJECT, dsm_pkg::CHAR_STAR);
        send_item(dsm_pkg::OP_REPORT, 8'h00);
        // Byte zero as a literal pattern element.
        send_item(dsm_pkg::OP_APPEND, 8'h00);
        send_item(dsm_pkg::OP_SUBJECT, 8'h00);
        send_item(dsm_pkg::OP_REPORT, 8'hFF);

        // First random job gets a long pattern that often overruns the element store.
        run_job(1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 600) begin
                // Receiver stalls for a long stretch while reports keep coming.
                hold_done    = 1'b1;
                hold_results = 1'b1;
                repeat (40)
                    send_item(dsm_pkg::OP_REPORT, rand_byte());
            end
            if (!drain_done && items_sent >= 1100) begin
                // Sender goes quiet until every report is back.
                drain_done = 1'b1;
                push <= 1'b0;
                while (model.pending() != 0)
                    @(posedge clk);
            end
            // Per-job idling on or off; none at all in the closing stretch.
            late    = (items_sent >= ITEM_TARGET - 250);
            tx_gaps = !late && ($urandom_range(0, 3) != 0);
            rx_gaps = !late && ($urandom_range(0, 3) != 0);
            run_job(1'b0);
        end

        push <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (model.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
